// ===== rtl/core/mosc_pkg.sv =====
// Package for the morphing oscillator pair: widths, fixed-point constants,
// shared types for the divider handshake. No dependencies.
`timescale 1ns / 1ps
package mosc_pkg;
    localparam int CountFracBits = 16;
    localparam int SampleBits    = 16;
    localparam int Fb            = SampleBits - 1;
    localparam int CountBits     = 28 + CountFracBits;
    localparam int DivBits       = 64;
    localparam int DivCntBits    = 7;

    localparam logic signed [31:0] One      = 32'sd1 <<< Fb;
    localparam logic signed [31:0] PtNine   = (9 * One + 5) / 10;
    localparam logic signed [31:0] PtZeroOne = (One + 50) / 100;
    localparam logic signed [31:0] PtThree  = (3 * One + 5) / 10;
    localparam logic signed [31:0] Jump     = (3 * One) / 4;
    localparam logic [CountBits-1:0] CountOne = CountBits'(1) << CountFracBits;

    localparam logic [1:0] AddrRate = 2'd0;
    localparam logic [1:0] AddrSync = 2'd1;

    typedef struct packed {
        logic               start;
        logic [DivBits-1:0] num;
        logic [DivBits-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DivBits-1:0] quo;
    } t_div_rsp;
endpackage

// ===== rtl/core/mosc_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on mosc_pkg for widths and request/response types.
`timescale 1ns / 1ps
module mosc_div import mosc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [DivCntBits-1:0] r_cnt, n_cnt;
    logic [DivBits-1:0] r_q, n_q;
    logic [DivBits-1:0] r_r, n_r;
    logic [DivBits-1:0] r_d, n_d;
    logic [DivBits:0]   w_sh;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_r    = r_r;
        n_d    = r_d;
        w_sh   = {r_r, r_q[DivBits-1]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_req.num;
            n_r    = '0;
            n_d    = i_req.den;
        end else if (r_busy) begin
            n_q = {r_q[DivBits-2:0], 1'b0};
            if (w_sh >= {1'b0, r_d}) begin
                n_r    = DivBits'(w_sh - {1'b0, r_d});
                n_q[0] = 1'b1;
            end else begin
                n_r = w_sh[DivBits-1:0];
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DivCntBits'(DivBits - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q <= n_q;
        r_r <= n_r;
        r_d <= n_d;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy)) else $error("divider done without work");
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy) else $error("divider restarted while busy");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("divider done held");
endmodule

// ===== rtl/core/morphing_oscillator_pair_with_sub.sv =====
// Morphing oscillator pair with sub oscillator: one sample transaction in,
// one out. A sample runs the sub, oscillator one and oscillator two in turn
// through one shared 64-step restoring divider. An oscillator issues a period
// reload on a counter wrap (two with hard sync on oscillator one), one phase
// division, and up to two morph quotients, at most 11 divisions in all.
// The block holds o_stall high while a sample is in work and while a result
// waits in the output register. Configuration (sample_rate at 0x0,
// hard_sync at 0x4) is to be written through the APB-style port only while
// idle; the user must keep to this, the block itself does not enforce it.
// Depends on mosc_pkg and mosc_div.
`timescale 1ns / 1ps
module morphing_oscillator_pair_with_sub import mosc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [23:0] i_freq_one,
    input  logic [23:0] i_freq_two,
    input  logic [16:0] i_shape_one,
    input  logic [16:0] i_shape_two,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [SampleBits-1:0] o_sub_out,
    output logic signed [SampleBits-1:0] o_osc_one_out,
    output logic signed [SampleBits-1:0] o_osc_two_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_WRAP  = 11'b00000000010,
        S_PER   = 11'b00000000100,
        S_PHASE = 11'b00000001000,
        S_PFRAC = 11'b00000010000,
        S_SQ    = 11'b00000100000,
        S_MA    = 11'b00001000000,
        S_BDIV  = 11'b00010000000,
        S_CDIV  = 11'b00100000000,
        S_FIN   = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    // unit index: 0 sub, 1 osc one, 2 osc two, 3 sync reload of period two
    t_state r_st;
    logic [1:0] r_u;
    logic [17:0] r_rate;
    logic        r_sync;
    logic [23:0] r_f1, r_f2;
    logic [16:0] r_s1, r_s2;
    logic [CountBits-1:0] r_per [3];
    logic [CountBits-1:0] r_cnt [3];
    logic signed [31:0] r_prev [2];
    logic signed [SampleBits-1:0] r_o [3];
    logic r_ov;
    logic [31:0] r_p, r_a;
    logic signed [31:0] r_b;
    t_div_req r_req;
    t_div_rsp w_rsp;

    mosc_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(r_req), .o_rsp(w_rsp));

    logic w_act1, w_act2, w_in;
    assign w_act1 = (r_f1 != 0) && ({8'd0, r_f1} < {8'd0, r_rate, 6'd0});
    assign w_act2 = (r_f2 != 0) && ({8'd0, r_f2} < {8'd0, r_rate, 6'd0});
    assign w_in = i_valid && !o_stall;
    assign o_stall = (r_st != S_IDLE) || r_ov;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == AddrSync[0]) ? {31'd0, r_sync} : {14'd0, r_rate};

    logic [1:0] w_pi;      // period/counter slot of current unit
    logic [23:0] w_f;
    logic [16:0] w_s;
    logic signed [31:0] w_sh, w_ma, w_mb, w_gain, w_c, w_d, w_cs;
    logic [63:0] w_pq;
    logic [DivBits-1:0] w_pnum;
    always_comb begin
        w_pi = (r_u == 2'd3) ? 2'd2 : r_u;
        w_f  = (r_u == 2'd0 || r_u == 2'd1) ? r_f1 : r_f2;
        w_s  = (r_u == 2'd1) ? r_s1 : r_s2;
        w_sh = 32'((64'(w_s) * 64'd3 << Fb) >> 16) - One;
        w_ma = (w_sh < One) ? One : ((w_sh > 2 * One) ? 2 * One : w_sh);
        w_mb = (w_sh < -One) ? -One : ((w_sh > One) ? One : w_sh);
        w_gain = ((w_ma - One) >>> 1) + PtThree;
        w_pnum = DivBits'({46'd0, r_rate}) << ((r_u == 2'd0 ? 9 : 8) + CountFracBits);
        w_pq = 64'(r_p) * 64'(r_p);
        w_c = r_b;
        w_cs = (w_c < -One) ? -One : ((w_c > One - 1) ? One - 1 : w_c);
        w_d = w_cs - r_prev[r_u[1]];
    end

    always_ff @(posedge i_clk) begin
        logic [CountBits-1:0] v_per;
        logic signed [31:0] v_c, v_o;
        logic signed [63:0] v_fl;
        logic [63:0] v_q;
        logic v_go;
        v_go = 1'b0;
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_ov   <= 1'b0;
            r_rate <= 18'd44100;
            r_sync <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_per[i] <= CountOne;
                r_cnt[i] <= '0;
            end
            r_prev[0] <= '0;
            r_prev[1] <= '0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr[2] == AddrRate[0]) r_rate <= pwdata[17:0];
                else r_sync <= pwdata[0];
            end
            if (r_ov && !i_stall) r_ov <= 1'b0;
            case (r_st)
                S_IDLE: if (w_in) begin
                    r_f1 <= i_freq_one; r_f2 <= i_freq_two;
                    r_s1 <= i_shape_one; r_s2 <= i_shape_two;
                    r_o[0] <= '0; r_o[1] <= '0; r_o[2] <= '0;
                    r_u <= 2'd0;
                    r_st <= S_WRAP;
                end
                S_WRAP: begin
                    if ((r_u[1] ? w_act2 : w_act1) == 1'b0) begin
                        // skip inactive oscillator, hold its state
                        r_st <= S_FIN;
                    end else if (r_cnt[w_pi] >= r_per[w_pi]) begin
                        r_cnt[w_pi] <= r_cnt[w_pi] - r_per[w_pi];
                        v_go = 1'b1;
                        r_req.num <= w_pnum;
                        r_req.den <= DivBits'(w_f);
                        r_st <= S_PER;
                    end else begin
                        r_st <= S_PHASE;
                        v_go = 1'b1;
                        r_req.num <= DivBits'(r_cnt[w_pi]) << Fb;
                        r_req.den <= DivBits'(r_per[w_pi]);
                    end
                end
                S_PER: if (w_rsp.done) begin
                    v_per = (w_rsp.quo == 0) ? CountBits'(1) : w_rsp.quo[CountBits-1:0];
                    if (r_u == 2'd3) begin
                        r_per[2] <= v_per;
                        r_u <= 2'd1;
                        r_st <= S_PFRAC;
                        v_go = 1'b1;
                        r_req.num <= DivBits'(r_cnt[1]) << Fb;
                        r_req.den <= DivBits'(r_per[1]);
                    end else begin
                        r_per[w_pi] <= v_per;
                        if (r_u == 2'd1 && r_sync) begin
                            r_cnt[2] <= r_cnt[1];
                        end
                        if (r_u == 2'd1 && r_sync && r_f2 != 0) begin
                            r_u <= 2'd3;
                            v_go = 1'b1;
                            r_req.num <= DivBits'({46'd0, r_rate}) << (8 + CountFracBits);
                            r_req.den <= DivBits'(r_f2);
                            r_st <= S_PER;
                        end else begin
                            v_go = 1'b1;
                            r_req.num <= DivBits'(r_cnt[w_pi]) << Fb;
                            r_req.den <= DivBits'(v_per);
                            r_st <= S_PFRAC;
                        end
                    end
                end
                S_PHASE: r_st <= S_PFRAC;
                S_PFRAC: if (w_rsp.done) begin
                    // fraction bits come with the shifted numerator; cap at 4.0
                    r_p <= (w_rsp.quo >= (64'd4 << Fb)) ? (32'd4 << Fb) : w_rsp.quo[31:0];
                    r_st <= S_SQ;
                end
                S_SQ: begin
                    r_a <= 32'(w_pq >> Fb);
                    r_st <= (r_u == 2'd0) ? S_FIN : S_MA;
                    if (r_u == 2'd0) begin
                        v_c = 2 * 32'(w_pq >> Fb) - One;
                        v_o = (v_c > 0) ? One - 2 * v_c : One + 2 * v_c;
                        r_o[0] <= (v_o < -One) ? -SampleBits'(One)
                                : ((v_o > One - 1) ? SampleBits'(One - 1) : SampleBits'(v_o));
                    end
                end
                S_MA: begin
                    v_q = (64'(r_a) * 64'(2 * w_ma)) >> Fb;
                    if (v_q > 64'(2 * One)) begin
                        v_go = 1'b1;
                        r_req.num <= (v_q - 64'(2 * One)) << Fb;
                        r_req.den <= 64'(w_ma - PtNine);
                        r_st <= S_BDIV;
                    end else begin
                        r_b <= 32'(v_q) - One;
                        r_st <= S_BDIV;
                        r_a <= 32'hFFFF_FFFF;
                    end
                end
                S_BDIV: if (r_a == 32'hFFFF_FFFF || w_rsp.done) begin
                    v_c = (r_a == 32'hFFFF_FFFF) ? r_b : One - 32'(w_rsp.quo);
                    if (v_c >= w_mb) begin
                        r_b <= One; r_st <= S_OUT;
                    end else if (v_c > -w_mb) begin
                        v_go = 1'b1;
                        r_req.num <= 64'(v_c < 0 ? -v_c : v_c) << Fb;
                        r_req.den <= 64'(w_mb + PtZeroOne);
                        r_a <= {31'd0, v_c < 0};
                        r_st <= S_CDIV;
                    end else begin
                        r_b <= -One; r_st <= S_OUT;
                    end
                end
                S_CDIV: if (w_rsp.done) begin
                    r_b <= r_a[0] ? -32'(w_rsp.quo) : 32'(w_rsp.quo);
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    v_c = w_cs;
                    if (w_d > Jump || w_d < -Jump) v_c = (w_cs + r_prev[r_u[1]]) >>> 1;
                    r_prev[r_u[1]] <= v_c;
                    v_fl = (64'(v_c) * 64'(w_gain)) >>> Fb;
                    r_o[r_u] <= (v_fl < -64'(One)) ? -SampleBits'(One)
                        : ((v_fl > 64'(One - 1)) ? SampleBits'(One - 1) : SampleBits'(v_fl));
                    r_st <= S_FIN;
                end
                S_FIN: begin
                    if ((r_u[1] ? w_act2 : w_act1))
                        r_cnt[w_pi] <= r_cnt[w_pi] + CountOne;
                    if (r_u == 2'd2) begin
                        r_st <= S_IDLE;
                        r_ov <= 1'b1;
                    end else begin
                        r_u <= r_u + 2'd1;
                        r_st <= S_WRAP;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
        r_req.start <= v_go;
    end

    assign o_valid = r_ov;
    assign o_sub_out = r_o[0];
    assign o_osc_one_out = r_o[1];
    assign o_osc_two_out = r_o[2];

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st != S_IDLE) |-> o_stall) else $error("ready while busy");
    a_ov_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_st == S_FIN)) else $error("result without finish");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_stall) |=> r_ov) else $error("result dropped");
endmodule
